### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/rc16_pkg.sv
// ---------------------------------------------------------------------------
// rc16_pkg
// Constants and the mod-65535 fold for the recurrence checksum.
// ---------------------------------------------------------------------------
package rc16_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TERM_W  = 16;
  localparam int unsigned PROD_W  = 25;

  localparam logic [7:0]  COEF_A       = 8'd17;
  localparam logic [7:0]  COEF_B       = 8'd31;
  localparam logic [7:0]  FIRST_OFFSET = 8'd7;
  localparam logic [15:0] MODULUS      = 16'hFFFF;

  // x mod 65535, using 2^16 = 1 (mod 65535); one correction suffices
  function automatic logic [TERM_W-1:0] fold(input logic [PROD_W-1:0] x);
    logic [TERM_W:0] s;
    s = 17'(x[PROD_W-1:TERM_W]) + 17'(x[TERM_W-1:0]);
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[TERM_W-1:0];
  endfunction

endpackage

### src/recurrence_checksum_16.sv
// ---------------------------------------------------------------------------
// recurrence_checksum_16
// Streaming three-term recurrence checksum over a byte message.
// ---------------------------------------------------------------------------
//  channel | signals                         | word
//  --------+---------------------------------+------------------------------
//  in      | in_valid, in_stall              | data_byte, last_byte
//  out     | out_valid, out_stall            | checksum (after a last byte)
//
//  One byte per cycle while in_stall is low; a checksum follows its last
//  byte through the input register, then the single-pass term update into
//  the result register. The term recurrence closes through two small
//  multipliers and the mod-65535 fold.
//  Reset (rst, synchronous) clears both stages and restarts the message.
//  out_stall holds a pending checksum; only a last byte waits behind it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module recurrence_checksum_16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] checksum
);

  localparam int unsigned TW = rc16_pkg::TERM_W;
  localparam int unsigned PW = rc16_pkg::PROD_W;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_data;
  logic       in_q_last;

  // recurrence state
  logic [7:0]    byte_position;
  logic          first_pending;
  logic [TW-1:0] older_term;
  logic [TW-1:0] newer_term;

  logic [7:0]    byte_position_next;
  logic          first_pending_next;
  logic [TW-1:0] older_term_next;
  logic [TW-1:0] newer_term_next;

  logic          proceed;
  logic [7:0]    coef_a;
  logic [7:0]    coef_b;
  logic [8:0]    mult_a;
  logic [PW-1:0] prod_a;
  logic [PW-1:0] prod_b;
  logic [TW-1:0] deficit_mod;
  logic [TW-1:0] step_value;

  // a word may leave the input register unless it is last and the result
  // register still holds a checksum under out_stall
  assign proceed  = in_q_valid && (!in_q_last || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !proceed;

  assign coef_a = byte_position * rc16_pkg::COEF_A;
  assign coef_b = byte_position * rc16_pkg::COEF_B;
  assign mult_a = {1'b0, in_q_data} + {1'b0, coef_a};
  assign prod_a = PW'(mult_a) * PW'(newer_term);
  assign prod_b = PW'(coef_b) * PW'(older_term);

  // a negative difference is taken as prod_b - prod_a: result is (1 - deficit) mod 65535
  assign deficit_mod = rc16_pkg::fold(prod_b - prod_a);

  always_comb begin
    if (prod_a >= prod_b) begin
      step_value = rc16_pkg::fold(prod_a - prod_b);
    end else if (deficit_mod <= 16'd1) begin
      step_value = 16'd1 - deficit_mod;
    end else begin
      step_value = TW'(17'h10000 - {1'b0, deficit_mod});
    end
  end

  always_comb begin
    if (first_pending) begin
      newer_term_next    = TW'({1'b0, in_q_data} + {1'b0, rc16_pkg::FIRST_OFFSET});
      older_term_next    = 16'd1;
      byte_position_next = 8'd1;
      first_pending_next = 1'b0;
    end else begin
      newer_term_next    = step_value;
      older_term_next    = newer_term;
      byte_position_next = byte_position + 8'd1;
      first_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall) begin
      in_q_data <= data_byte;
      in_q_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      first_pending <= 1'b1;
      older_term    <= 16'd1;
      newer_term    <= 16'd1;
    end else if (proceed) begin
      if (in_q_last) begin
        byte_position <= 8'd0;
        first_pending <= 1'b1;
        older_term    <= 16'd1;
        newer_term    <= 16'd1;
      end else begin
        byte_position <= byte_position_next;
        first_pending <= first_pending_next;
        older_term    <= older_term_next;
        newer_term    <= newer_term_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && in_q_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proceed && in_q_last) begin
      checksum <= newer_term_next;
    end
  end

  `ASSERT_SAME(a_chk_range, clk, rst, out_valid, checksum != rc16_pkg::MODULUS)
  `ASSERT_SAME(a_term_range, clk, rst, !first_pending, newer_term != rc16_pkg::MODULUS)
  `ASSERT_NEXT(a_last_restart, clk, rst, proceed && in_q_last, first_pending && (byte_position == 8'd0))
  `ASSERT_NEXT(a_last_result, clk, rst, proceed && in_q_last, out_valid)

endmodule
